>>> src/assert_macros.svh
// Assertion macros used by the checker file.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked property that is suspended while reset is high.
`define FFAB_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked property that also holds during reset.
`define FFAB_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> src/ffab_pkg.sv
`timescale 1ns / 1ps
// Types, widths and codes of the first-fit aligned block allocator.
// No dependencies; imported by every module of the block.
package ffab_pkg;

  localparam int ADDR_W       = 19;
  localparam int REGION_BYTES = 16384;
  localparam int OFF_W        = $clog2(REGION_BYTES);
  localparam int IDX_W        = OFF_W - 2;
  localparam int HDR_W        = OFF_W + 2;
  localparam int NXT_W        = OFF_W + 2;
  localparam int RW           = ADDR_W + 1;
  localparam int XW           = ADDR_W + 1;
  localparam int LOC_W        = XW + 1;
  localparam int END_W        = LOC_W + 1;
  localparam int CNT_W        = $clog2(XW) + 1;

  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NO_MEM    = 3'd1,
    ST_ZERO      = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_NULL      = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    E_CLEAR, E_IDLE, E_READ, E_HDR, E_DIV, E_FIT, E_ANXT,
    E_AGAP, E_AUSED, E_ATAIL, E_FNXT, E_FWR, E_DONE
  } eng_state_t;

  typedef struct packed {
    logic              action;
    logic [ADDR_W-1:0] size;
    logic [ADDR_W-1:0] align;
    logic [ADDR_W-1:0] faddr;
  } req_t;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    status_t           status;
  } res_t;

  function automatic logic [RW-1:0] round4(input logic [ADDR_W-1:0] v);
    logic [RW-1:0] s;
    s = RW'(v) + RW'(3);
    return s & ~RW'(3);
  endfunction

endpackage

>>> src/ffab_rem.sv
`timescale 1ns / 1ps
// Bit-serial remainder unit: dividend mod divisor, one quotient bit a cycle.
// Depends on ffab_pkg.
module ffab_rem import ffab_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [XW-1:0] dividend,
  input  logic [RW-1:0] divisor,
  output logic          done,
  output logic [RW-1:0] rem
);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [XW-1:0]    xs;
  logic [RW:0]      t;
  logic [RW-1:0]    r_step;

  always_comb begin
    t = {rem, xs[XW-1]};
    if (t >= {1'b0, divisor}) begin
      r_step = RW'(t - {1'b0, divisor});
    end else begin
      r_step = RW'(t);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        xs   <= dividend;
        rem  <= '0;
      end else if (busy) begin
        rem <= r_step;
        xs  <= xs << 1;
        cnt <= cnt + CNT_W'(1);
        if (cnt == CNT_W'(XW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

>>> src/ffab_engine.sv
`timescale 1ns / 1ps
// Header store and the walk sequencer for allocate and free requests.
// Depends on ffab_pkg and ffab_rem.
module ffab_engine import ffab_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              init,
  input  logic [ADDR_W-1:0] base,
  input  logic              req_valid,
  output logic              req_ready,
  input  req_t              req,
  output logic              res_valid,
  input  logic              res_ready,
  output res_t              res
);

  localparam int WORDS_DUMMY_GUARD = REGION_BYTES / 4;
  logic [HDR_W-1:0] mem [WORDS_DUMMY_GUARD];

  logic             mem_we;
  logic [IDX_W-1:0] mem_addr;
  logic [HDR_W-1:0] mem_wdata;
  logic [HDR_W-1:0] mem_rdata;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    mem_rdata <= mem[mem_addr];
  end

  eng_state_t        state, state_next;
  logic [IDX_W-1:0]  clr_idx, clr_idx_next;
  logic              is_free, is_free_next;
  logic [RW-1:0]     size, size_next;
  logic [RW-1:0]     align, align_next;
  logic [ADDR_W-1:0] faddr, faddr_next;
  logic [OFF_W-1:0]  off, off_next;
  logic [OFF_W-1:0]  prev, prev_next;
  logic [HDR_W-1:0]  prev_h, prev_h_next;
  logic              have_prev, have_prev_next;
  logic [NXT_W-1:0]  nxt, nxt_next;
  logic [XW-1:0]     xr, xr_next;
  logic [LOC_W-1:0]  loc, loc_next;
  logic [NXT_W-1:0]  end_off, end_off_next;
  logic [HDR_W-1:0]  nh, nh_next;
  res_t              res_next;

  logic              rem_start;
  logic              rem_done;
  logic [RW-1:0]     rem_val;

  ffab_rem u_rem (
    .clk      (clk),
    .rst      (rst),
    .start    (rem_start),
    .dividend (xr_next),
    .divisor  (align),
    .done     (rem_done),
    .rem      (rem_val)
  );

  logic             h_pos, h_neg, prev_free, nxt_out;
  logic [HDR_W-1:0] span;
  logic [NXT_W-1:0] nxt_c, adv_to;
  logic [XW-1:0]    hdr_abs;
  logic [LOC_W-1:0] aligned;
  logic [END_W-1:0] end_c;
  logic [OFF_W-1:0] tgt;
  logic [NXT_W:0]   tail_end;
  logic             do_adv;
  logic [RW-1:0]    rsz, ral;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= E_CLEAR;
      clr_idx <= '0;
    end else begin
      state   <= state_next;
      clr_idx <= clr_idx_next;
    end
    is_free   <= is_free_next;
    size      <= size_next;
    align     <= align_next;
    faddr     <= faddr_next;
    off       <= off_next;
    prev      <= prev_next;
    prev_h    <= prev_h_next;
    have_prev <= have_prev_next;
    nxt       <= nxt_next;
    xr        <= xr_next;
    loc       <= loc_next;
    end_off   <= end_off_next;
    nh        <= nh_next;
    res       <= res_next;
  end

  always_comb begin
    state_next     = state;
    clr_idx_next   = clr_idx;
    is_free_next   = is_free;
    size_next      = size;
    align_next     = align;
    faddr_next     = faddr;
    off_next       = off;
    prev_next      = prev;
    prev_h_next    = prev_h;
    have_prev_next = have_prev;
    nxt_next       = nxt;
    xr_next        = xr;
    loc_next       = loc;
    end_off_next   = end_off;
    nh_next        = nh;
    res_next       = res;
    mem_we         = 1'b0;
    mem_addr       = off[OFF_W-1:2];
    mem_wdata      = '0;
    rem_start      = 1'b0;
    req_ready      = 1'b0;
    res_valid      = 1'b0;
    do_adv         = 1'b0;
    adv_to         = nxt;

    h_neg     = mem_rdata[HDR_W-1];
    h_pos     = !mem_rdata[HDR_W-1] && (mem_rdata != '0);
    span      = h_neg ? (-mem_rdata) : mem_rdata;
    nxt_c     = NXT_W'(off) + NXT_W'(span);
    hdr_abs   = XW'(base) + XW'(off) + XW'(4);
    prev_free = have_prev && !prev_h[HDR_W-1] && (prev_h != '0);
    nxt_out   = nxt >= NXT_W'(REGION_BYTES);
    aligned   = LOC_W'(xr) + ((rem_val == '0) ? '0 : LOC_W'(align - rem_val));
    end_c     = END_W'(loc) + END_W'(size);
    tgt       = prev_free ? prev : off;
    tail_end  = nh[HDR_W-1] || (nh == '0) ?
                (NXT_W + 1)'(nxt) - (NXT_W + 1)'(end_off) :
                (NXT_W + 1)'(nxt) + (NXT_W + 1)'(nh) - (NXT_W + 1)'(end_off);
    rsz       = round4(req.size);
    ral       = round4(req.align);

    case (state)
      E_CLEAR: begin
        mem_we       = 1'b1;
        mem_addr     = clr_idx;
        mem_wdata    = (clr_idx == '0) ? HDR_W'(REGION_BYTES - 4) : '0;
        clr_idx_next = clr_idx + IDX_W'(1);
        if (clr_idx == IDX_W'(REGION_BYTES / 4 - 1)) begin
          state_next = E_IDLE;
        end
      end
      E_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          is_free_next   = (req.action == ACT_FREE);
          size_next      = rsz;
          align_next     = ral;
          faddr_next     = req.faddr;
          off_next       = '0;
          have_prev_next = 1'b0;
          res_next.addr  = '0;
          if (req.action == ACT_ALLOC && (rsz == '0 || ral == '0)) begin
            res_next.status = ST_ZERO;
            state_next      = E_DONE;
          end else if (req.action == ACT_FREE && req.faddr == '0) begin
            res_next.status = ST_NULL;
            state_next      = E_DONE;
          end else begin
            state_next = E_READ;
          end
        end
      end
      E_READ: begin
        state_next = E_HDR;
      end
      E_HDR: begin
        nxt_next = nxt_c;
        adv_to   = nxt_c;
        if (mem_rdata == '0) begin
          res_next.status = is_free ? ST_NOT_FOUND : ST_NO_MEM;
          state_next      = E_DONE;
        end else if (!is_free && h_pos) begin
          xr_next    = hdr_abs;
          rem_start  = 1'b1;
          state_next = E_DIV;
        end else if (is_free && h_neg && ADDR_W'(hdr_abs) == faddr) begin
          if (nxt_c >= NXT_W'(REGION_BYTES)) begin
            nh_next    = '0;
            state_next = E_FWR;
          end else begin
            mem_addr   = nxt_c[OFF_W-1:2];
            state_next = E_FNXT;
          end
        end else begin
          do_adv = 1'b1;
        end
        if (do_adv) begin
          prev_h_next = mem_rdata;
        end
      end
      E_DIV: begin
        if (rem_done) begin
          loc_next   = aligned - LOC_W'(base);
          state_next = E_FIT;
        end
      end
      E_FIT: begin
        if (end_c <= END_W'(nxt)) begin
          end_off_next  = NXT_W'(end_c);
          res_next.addr = ADDR_W'(loc + LOC_W'(base));
          nh_next       = '0;
          if (end_c < END_W'(nxt) && !nxt_out) begin
            mem_addr   = nxt[OFF_W-1:2];
            state_next = E_ANXT;
          end else begin
            state_next = E_AGAP;
          end
        end else begin
          do_adv = 1'b1;
          // The header of this block is unchanged since it was read.
          prev_h_next = HDR_W'(nxt - NXT_W'(off));
        end
      end
      E_ANXT: begin
        nh_next    = mem_rdata;
        state_next = E_AGAP;
      end
      E_AGAP: begin
        if (loc > LOC_W'(off) + LOC_W'(4)) begin
          mem_we    = 1'b1;
          mem_addr  = tgt[OFF_W-1:2];
          mem_wdata = HDR_W'(loc - LOC_W'(4) - LOC_W'(tgt));
          off_next  = OFF_W'(loc - LOC_W'(4));
        end
        state_next = E_AUSED;
      end
      E_AUSED: begin
        mem_we    = 1'b1;
        mem_addr  = off[OFF_W-1:2];
        mem_wdata = HDR_W'(NXT_W'(off) - end_off);
        if (end_off < nxt) begin
          state_next = E_ATAIL;
        end else begin
          res_next.status = ST_OK;
          state_next      = E_DONE;
        end
      end
      E_ATAIL: begin
        mem_we          = (end_off < NXT_W'(REGION_BYTES));
        mem_addr        = end_off[OFF_W-1:2];
        mem_wdata       = HDR_W'(tail_end);
        res_next.status = ST_OK;
        state_next      = E_DONE;
      end
      E_FNXT: begin
        nh_next    = mem_rdata;
        state_next = E_FWR;
      end
      E_FWR: begin
        mem_we    = 1'b1;
        mem_addr  = tgt[OFF_W-1:2];
        mem_wdata = (nh[HDR_W-1] || nh == '0) ? HDR_W'(nxt - NXT_W'(tgt)) :
                    HDR_W'(nxt + NXT_W'(nh) - NXT_W'(tgt));
        res_next.status = ST_OK;
        state_next      = E_DONE;
      end
      E_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_next = E_IDLE;
        end
      end
      default: begin
        state_next = E_IDLE;
      end
    endcase

    if (do_adv) begin
      prev_next      = off;
      have_prev_next = 1'b1;
      if (adv_to >= NXT_W'(REGION_BYTES)) begin
        res_next.status = is_free ? ST_NOT_FOUND : ST_NO_MEM;
        state_next      = E_DONE;
      end else begin
        off_next   = adv_to[OFF_W-1:0];
        state_next = E_READ;
      end
    end

    if (init) begin
      clr_idx_next = '0;
      state_next   = E_CLEAR;
    end
  end

endmodule

>>> src/first_fit_aligned_block_allocator_top.sv
`timescale 1ns / 1ps
// Top level: stream ports, APB register, output register around the engine.
// Depends on ffab_pkg and ffab_engine.
//
//  channel   direction  handshake          payload
//  s_*       in         s_tvalid/s_tready  tuser action, tdata request fields
//  m_*       out        m_tvalid/m_tready  tdata block_address, status
//  apb       in         psel/penable       region_base at byte address 0
//
// After reset and after every write of region_base a clearing pass rewrites all
// REGION_BYTES/4 (4096) words of the header store; no item is taken then.
// An item reads the header of each block visited; each free block tested for
// alignment also passes the bit-serial remainder unit and a fit check. Then
// headers are read and written, the result is handed over, and the engine goes
// idle to take the next item. One item is in work at a time; a result waiting
// in the output register does not stop the next item from being accepted.
module first_fit_aligned_block_allocator_top import ffab_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // request_size, request_alignment, free_address, pad
  input  logic        s_tuser,   // action
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // block_address, status, pad
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [ADDR_W-1:0] region_base;
  logic              cfg_wr;
  req_t              req;
  res_t              res;
  logic              res_valid;
  logic              res_ready;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == 1'b0);
  assign prdata = (paddr[2] == 1'b0) ? 32'(region_base) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      region_base <= ADDR_W'(4096);
    end else if (cfg_wr) begin
      region_base <= pwdata[ADDR_W-1:0] & ~ADDR_W'(3);
    end
  end

  assign req.action = s_tuser;
  assign req.size   = s_tdata[ADDR_W-1:0];
  assign req.align  = s_tdata[2*ADDR_W-1:ADDR_W];
  assign req.faddr  = s_tdata[3*ADDR_W-1:2*ADDR_W];

  ffab_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .init      (cfg_wr),
    .base      (region_base),
    .req_valid (s_tvalid),
    .req_ready (s_tready),
    .req       (req),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_valid && res_ready) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
    if (res_valid && res_ready) begin
      m_tdata <= {2'b00, res.status, res.addr};
    end
  end

endmodule

>>> src/ffab_checker.sv
`timescale 1ns / 1ps
// Port-level checks of the allocator, bound to the top level.
// Depends on ffab_pkg and assert_macros.svh.
`include "assert_macros.svh"

module ffab_checker import ffab_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [23:0] m_tdata
);

  // The store is swept after reset, so no item may be taken right away.
  `FFAB_ASSERT_ALWAYS(a_clear_after_reset, clk, rst |=> !s_tready, "item taken during clear")

  // One item is in work at a time.
  `FFAB_ASSERT(a_one_item, clk, rst, s_tvalid && s_tready |=> !s_tready, "second item taken")

  `FFAB_ASSERT(a_fail_no_addr, clk, rst,
    m_tvalid && m_tdata[21:19] != ST_OK |-> m_tdata[18:0] == 19'd0, "failed item with address")

  `FFAB_ASSERT(a_out_hold, clk, rst,
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "stalled item changed")

endmodule

bind first_fit_aligned_block_allocator_top ffab_checker u_ffab_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
